[rtl/core/rcgp_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rcgp_pkg: shared types, constants and helpers of the pixel grading pipeline
// Holds the fixed-point format, the payload structs that travel between the
// pipeline sections, the register map and the saturation helpers.
// ---------------------------------------------------------------------------
package rcgp_pkg;

    // Fixed-point format of the channel values.
    localparam int FRAC_BITS = 12;
    localparam int CHAN_W    = 24;
    localparam logic signed [63:0] ONE_L = 64'sd1 <<< FRAC_BITS;
    localparam logic signed [63:0] LIM_L = 64'sd1 <<< (FRAC_BITS + 10);

    // Rec.601 luma weights and the chroma threshold, rounded to FRAC_BITS.
    localparam logic signed [12:0] LUMA_KR = 13'sd1225;
    localparam logic signed [12:0] LUMA_KG = 13'sd2404;
    localparam logic signed [12:0] LUMA_KB = 13'sd467;
    localparam logic signed [23:0] CHROMA_MIN = 24'sd4;

    // Reciprocal of 255 scaled by 2^29, rounded up.
    localparam logic [42:0] RECIP_255 = 43'd2105377;

    // Squared distance from the image center.
    localparam int DX_W = 20;
    localparam int SQ_W = 33;
    localparam int D2_W = 34;

    // Chroma ratio divider: dividend, divisor, remainder and bits per stage.
    localparam int NUM_W      = 36;
    localparam int DEN_W      = 23;
    localparam int REM_W      = DEN_W + 1;
    localparam int DIV_BITS   = 3;
    localparam int DIV_STAGES = NUM_W / DIV_BITS;

    typedef logic signed [CHAN_W-1:0] t_chan;

    // Incoming pixel as packed in the input tdata.
    typedef struct packed {
        logic [11:0] row;
        logic [11:0] column;
        logic [7:0]  blue;
        logic [7:0]  green;
        logic [7:0]  red;
    } t_pix;

    // Pixel in flight: three channels, its luma and squared center distance.
    typedef struct packed {
        t_chan [2:0]      chan;
        t_chan            luma;
        logic [D2_W-1:0]  dist2;
    } t_grade;

    // Saturated channels ready for the vignette multiply.
    typedef struct packed {
        t_chan [2:0] chan;
        t_chan       vfac;
    } t_mix;

    // Configuration registers.
    typedef struct packed {
        logic [31:0]        white_balance;
        logic [17:0]        exposure_gain;
        logic [13:0]        contrast_gain;
        logic [13:0]        saturation_gain;
        logic signed [13:0] vibrance_amount;
        logic [63:0]        tone_amounts;
        logic signed [47:0] vignette_scale;
        logic [31:0]        image_size;
    } t_cfg;

    typedef enum logic [2:0] {
        REG_WHITE_BALANCE   = 3'd0,
        REG_EXPOSURE_GAIN   = 3'd1,
        REG_CONTRAST_GAIN   = 3'd2,
        REG_SATURATION_GAIN = 3'd3,
        REG_VIBRANCE_AMOUNT = 3'd4,
        REG_TONE_AMOUNTS    = 3'd5,
        REG_VIGNETTE_SCALE  = 3'd6,
        REG_IMAGE_SIZE      = 3'd7
    } t_cfg_reg;

    // Clamp a wide signed value to the working range of a channel.
    function automatic t_chan sat_chan(input logic signed [63:0] v);
        if (v > LIM_L) begin
            return t_chan'(LIM_L);
        end else if (v < -LIM_L) begin
            return t_chan'(-LIM_L);
        end
        return t_chan'(v);
    endfunction

    // Map an 8-bit code to the fixed-point scale with rounding. The division
    // by 255 is a multiply by the reciprocal, exact over the whole code range.
    function automatic logic [12:0] to_fixed(input logic [7:0] p);
        logic [20:0] num;
        logic [42:0] prod;
        num  = {1'b0, p, 12'b0} + 21'd127;
        prod = {22'b0, num} * RECIP_255;
        return prod[41:29];
    endfunction

endpackage

[rtl/core/rcgp_tone.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rcgp_tone: tonal front end of the grading pipeline
// Eight stages: white balance, exposure, luma, contrast with tone lift,
// highlight or shadow add, whites and blacks lift, and the chroma extremes
// that feed the ratio divider. The center distance is formed alongside.
// ---------------------------------------------------------------------------
module rcgp_tone import rcgp_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  t_cfg             i_cfg,
    input  logic             i_valid,
    input  t_pix             i_pix,
    output logic             o_valid,
    output t_grade           o_grade,
    output logic [NUM_W-1:0] o_num,
    output logic [DEN_W-1:0] o_den,
    output logic             o_nz
);

    localparam int STAGES = 8;

    logic [STAGES-1:0] r_v;

    t_grade r1_g, n1_g, r2_g, n2_g, r3_g, n3_g, r4_g, n4_g;
    t_grade r5_g, n5_g, r6_g, n6_g, r7_g, n7_g, r8_g, n8_g;
    logic signed [DX_W-1:0] r1_dx, n1_dx, r1_dy, n1_dy;
    logic [SQ_W-1:0]        r2_sqx, n2_sqx, r2_sqy, n2_sqy;
    logic signed [29:0]     r4_lift, n4_lift, r6_lift, n6_lift;
    logic signed [28:0]     r5_blt, n5_blt;
    logic [NUM_W-1:0]       r8_num, n8_num;
    logic [DEN_W-1:0]       r8_den, n8_den;
    logic                   r8_nz, n8_nz;

    // Stage 1: code to fixed point, white balance, offsets from the center.
    always_comb begin
        t_chan temp;
        t_chan tint;
        logic signed [63:0] acc_r;
        logic signed [63:0] acc_g;
        logic signed [63:0] acc_b;
        temp  = t_chan'($signed(i_cfg.white_balance[15:0]));
        tint  = t_chan'($signed(i_cfg.white_balance[31:16]));
        acc_r = 64'($signed({1'b0, to_fixed(i_pix.red)})) + 64'(temp);
        acc_g = 64'($signed({1'b0, to_fixed(i_pix.green)})) + 64'(tint);
        acc_b = 64'($signed({1'b0, to_fixed(i_pix.blue)})) - 64'(temp);
        n1_g         = '0;
        n1_g.chan[0] = sat_chan(acc_r);
        n1_g.chan[1] = sat_chan(acc_g);
        n1_g.chan[2] = sat_chan(acc_b);
        n1_dx = $signed({7'b0, i_pix.column, 1'b0})
              - $signed({4'b0, i_cfg.image_size[15:0]});
        n1_dy = $signed({7'b0, i_pix.row, 1'b0})
              - $signed({4'b0, i_cfg.image_size[31:16]});
    end

    // Stage 2: exposure gain and squared offsets.
    always_comb begin
        t_chan x;
        logic signed [42:0] p;
        logic signed [2*DX_W-1:0] sx;
        logic signed [2*DX_W-1:0] sy;
        n2_g = r1_g;
        for (int i = 0; i < 3; i++) begin
            x = r1_g.chan[i];
            p = x * $signed({1'b0, i_cfg.exposure_gain});
            n2_g.chan[i] = sat_chan(64'(p >>> FRAC_BITS));
        end
        sx = r1_dx * r1_dx;
        sy = r1_dy * r1_dy;
        n2_sqx = sx[SQ_W-1:0];
        n2_sqy = sy[SQ_W-1:0];
    end

    // Stage 3: luma after exposure, squared distance.
    always_comb begin
        t_chan r;
        t_chan g;
        t_chan b;
        logic signed [39:0] lsum;
        r = r2_g.chan[0];
        g = r2_g.chan[1];
        b = r2_g.chan[2];
        lsum = r * LUMA_KR + g * LUMA_KG + b * LUMA_KB;
        n3_g       = r2_g;
        n3_g.luma  = sat_chan(64'(lsum >>> FRAC_BITS));
        n3_g.dist2 = {1'b0, r2_sqx} + {1'b0, r2_sqy};
    end

    // Stage 4: contrast about luma, highlight or shadow lift amount.
    always_comb begin
        t_chan x;
        t_chan l;
        logic signed [24:0] d;
        logic signed [39:0] p;
        logic signed [25:0] tw;
        logic signed [15:0] amt;
        logic signed [41:0] lp;
        l    = r3_g.luma;
        n4_g = r3_g;
        for (int i = 0; i < 3; i++) begin
            x = r3_g.chan[i];
            d = 25'(x) - 25'(l);
            p = d * $signed({1'b0, i_cfg.contrast_gain});
            n4_g.chan[i] = sat_chan(64'(l) + 64'(p >>> FRAC_BITS));
        end
        if (64'(l) > (ONE_L >>> 1)) begin
            tw  = (26'(l) - 26'(ONE_L >>> 1)) <<< 1;
            amt = $signed(i_cfg.tone_amounts[15:0]);
        end else begin
            tw  = (26'(ONE_L >>> 1) - 26'(l)) <<< 1;
            amt = $signed(i_cfg.tone_amounts[31:16]);
        end
        lp      = amt * tw;
        n4_lift = 30'(lp >>> FRAC_BITS);
    end

    // Stage 5: apply the tone lift, blacks term from luma.
    always_comb begin
        t_chan x;
        t_chan l;
        logic signed [24:0] om;
        logic signed [40:0] bp;
        logic signed [15:0] bl;
        l    = r4_g.luma;
        n5_g = r4_g;
        for (int i = 0; i < 3; i++) begin
            x = r4_g.chan[i];
            n5_g.chan[i] = sat_chan(64'(x) + 64'(r4_lift));
        end
        bl     = $signed(i_cfg.tone_amounts[63:48]);
        om     = 25'(ONE_L) - 25'(l);
        bp     = bl * om;
        n5_blt = 29'(bp >>> FRAC_BITS);
    end

    // Stage 6: peak channel, whites minus blacks lift.
    always_comb begin
        t_chan x;
        t_chan peak;
        logic signed [24:0] om;
        logic signed [40:0] wp;
        logic signed [15:0] wh;
        n6_g = r5_g;
        peak = r5_g.chan[0];
        for (int i = 1; i < 3; i++) begin
            x = r5_g.chan[i];
            if (x > peak) begin
                peak = x;
            end
        end
        wh      = $signed(i_cfg.tone_amounts[47:32]);
        om      = 25'(ONE_L) - 25'(peak);
        wp      = wh * om;
        n6_lift = 30'(wp >>> FRAC_BITS) - 30'(r5_blt);
    end

    // Stage 7: apply the whites and blacks lift.
    always_comb begin
        t_chan x;
        n7_g = r6_g;
        for (int i = 0; i < 3; i++) begin
            x = r6_g.chan[i];
            n7_g.chan[i] = sat_chan(64'(x) + 64'(r6_lift));
        end
    end

    // Stage 8: channel extremes and divider operands for the chroma ratio.
    always_comb begin
        t_chan x;
        t_chan cmax;
        t_chan cmin;
        logic signed [24:0] diff;
        n8_g = r7_g;
        cmax = r7_g.chan[0];
        cmin = r7_g.chan[0];
        for (int i = 1; i < 3; i++) begin
            x = r7_g.chan[i];
            if (x > cmax) begin
                cmax = x;
            end
            if (x < cmin) begin
                cmin = x;
            end
        end
        diff   = 25'(cmax) - 25'(cmin);
        n8_num = {diff[23:0], {FRAC_BITS{1'b0}}};
        n8_den = cmax[DEN_W-1:0];
        n8_nz  = (cmax > CHROMA_MIN);
    end

    // Valid bits travel with the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[STAGES-2:0], i_valid};
        end
    end

    // Data registers.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_g    <= n1_g;
            r1_dx   <= n1_dx;
            r1_dy   <= n1_dy;
            r2_g    <= n2_g;
            r2_sqx  <= n2_sqx;
            r2_sqy  <= n2_sqy;
            r3_g    <= n3_g;
            r4_g    <= n4_g;
            r4_lift <= n4_lift;
            r5_g    <= n5_g;
            r5_blt  <= n5_blt;
            r6_g    <= n6_g;
            r6_lift <= n6_lift;
            r7_g    <= n7_g;
            r8_g    <= n8_g;
            r8_num  <= n8_num;
            r8_den  <= n8_den;
            r8_nz   <= n8_nz;
        end
    end

    assign o_valid = r_v[STAGES-1];
    assign o_grade = r8_g;
    assign o_num   = r8_num;
    assign o_den   = r8_den;
    assign o_nz    = r8_nz;

    // Luma leaving stage 3 stays inside the working range.
    a_luma_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[2] |-> (64'(r3_g.luma) <= LIM_L) && (64'(r3_g.luma) >= -LIM_L))
        else $error("luma outside working range");

endmodule

[rtl/core/rcgp_div.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rcgp_div: pipelined restoring divider for the chroma ratio
// Resolves DIV_BITS quotient bits per stage; the pixel payload rides along.
// A pixel whose peak is at or below the threshold gets a zero ratio.
// ---------------------------------------------------------------------------
module rcgp_div import rcgp_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  t_grade           i_grade,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    input  logic             i_nz,
    output logic             o_valid,
    output t_grade           o_grade,
    output logic [NUM_W-1:0] o_ratio
);

    localparam int LAST = DIV_STAGES - 1;

    logic [DIV_STAGES-1:0] r_v;
    logic [DIV_STAGES-1:0] r_nz;
    t_grade                r_g   [DIV_STAGES];
    logic [REM_W-1:0]      r_rem [DIV_STAGES];
    logic [NUM_W-1:0]      r_dq  [DIV_STAGES];
    logic [DEN_W-1:0]      r_den [DIV_STAGES];
    logic [REM_W-1:0]      n_rem [DIV_STAGES];
    logic [NUM_W-1:0]      n_dq  [DIV_STAGES];

    // Each stage shifts DIV_BITS dividend bits into the remainder.
    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
        logic [REM_W-1:0] rem_in;
        logic [NUM_W-1:0] dq_in;
        logic [DEN_W-1:0] den_in;

        if (k == 0) begin : g_first
            assign rem_in = '0;
            assign dq_in  = i_num;
            assign den_in = i_den;
        end else begin : g_next
            assign rem_in = r_rem[k-1];
            assign dq_in  = r_dq[k-1];
            assign den_in = r_den[k-1];
        end

        always_comb begin
            logic [REM_W-1:0] rem;
            logic [NUM_W-1:0] dq;
            rem = rem_in;
            dq  = dq_in;
            for (int b = 0; b < DIV_BITS; b++) begin
                rem = {rem[REM_W-2:0], dq[NUM_W-1]};
                dq  = {dq[NUM_W-2:0], 1'b0};
                if (rem >= {1'b0, den_in}) begin
                    rem   = rem - {1'b0, den_in};
                    dq[0] = 1'b1;
                end
            end
            n_rem[k] = rem;
            n_dq[k]  = dq;
        end
    end

    // Valid bits travel with the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[DIV_STAGES-2:0], i_valid};
        end
    end

    // Stage registers.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_g[0]   <= i_grade;
            r_den[0] <= i_den;
            r_nz[0]  <= i_nz;
            for (int k = 1; k < DIV_STAGES; k++) begin
                r_g[k]   <= r_g[k-1];
                r_den[k] <= r_den[k-1];
                r_nz[k]  <= r_nz[k-1];
            end
            for (int k = 0; k < DIV_STAGES; k++) begin
                r_rem[k] <= n_rem[k];
                r_dq[k]  <= n_dq[k];
            end
        end
    end

    assign o_valid = r_v[LAST];
    assign o_grade = r_g[LAST];
    assign o_ratio = r_nz[LAST] ? r_dq[LAST] : '0;

    // A finished division leaves a remainder below the divisor.
    a_rem_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[LAST] && r_nz[LAST] |-> r_rem[LAST] < {1'b0, r_den[LAST]})
        else $error("divider remainder not below divisor");

endmodule

[rtl/core/rcgp_sat.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rcgp_sat: saturation with vibrance, and the vignette factor
// Five stages: vibrance product, vibrance factor, saturation factor, split
// channel products, recombination. The vignette factor is built alongside
// from partial products of the scale and the squared center distance.
// ---------------------------------------------------------------------------
module rcgp_sat import rcgp_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  t_cfg             i_cfg,
    input  logic             i_valid,
    input  t_grade           i_grade,
    input  logic [NUM_W-1:0] i_ratio,
    output logic             o_valid,
    output t_mix             o_mix
);

    localparam int STAGES = 5;
    localparam int FAC_W  = 38;
    localparam int HALF_W = D2_W / 2;
    localparam logic signed [42:0] FAC_MAX = (43'sd1 <<< (FAC_W - 1)) - 43'sd1;
    localparam logic signed [42:0] FAC_MIN = -(43'sd1 <<< (FAC_W - 1));

    logic [STAGES-1:0] r_v;

    t_grade r1_g, r2_g, r3_g, r4_g;
    logic signed [51:0]      r1_vp, n1_vp;
    logic signed [35:0]      r1_pl [3];
    logic signed [35:0]      r1_ph [3];
    logic signed [35:0]      n1_pl [3];
    logic signed [35:0]      n1_ph [3];
    logic signed [39:0]      r2_vib, n2_vib;
    logic signed [67:0]      r2_rl, n2_rl, r2_rh, n2_rh;
    logic signed [FAC_W-1:0] r3_fac, n3_fac;
    logic signed [87:0]      r3_tot, n3_tot;
    logic signed [43:0]      r4_ph [3];
    logic signed [44:0]      r4_pl [3];
    logic signed [43:0]      n4_ph [3];
    logic signed [44:0]      n4_pl [3];
    t_chan                   r4_vfac, n4_vfac;
    t_mix                    r5_mix, n5_mix;

    // Stage 1: vibrance times one minus ratio; scale by distance partials.
    always_comb begin
        logic signed [37:0] om;
        logic signed [17:0] dl;
        logic signed [17:0] dh;
        om    = 38'(ONE_L) - $signed({2'b0, i_ratio});
        n1_vp = i_cfg.vibrance_amount * om;
        dl    = $signed({1'b0, i_grade.dist2[HALF_W-1:0]});
        dh    = $signed({1'b0, i_grade.dist2[D2_W-1:HALF_W]});
        n1_pl[0] = $signed({1'b0, i_cfg.vignette_scale[15:0]}) * dl;
        n1_pl[1] = $signed({1'b0, i_cfg.vignette_scale[31:16]}) * dl;
        n1_pl[2] = $signed(i_cfg.vignette_scale[47:32]) * dl;
        n1_ph[0] = $signed({1'b0, i_cfg.vignette_scale[15:0]}) * dh;
        n1_ph[1] = $signed({1'b0, i_cfg.vignette_scale[31:16]}) * dh;
        n1_ph[2] = $signed(i_cfg.vignette_scale[47:32]) * dh;
    end

    // Stage 2: vibrance factor; row sums of the vignette partials.
    always_comb begin
        n2_vib = 40'(ONE_L) + 40'(r1_vp >>> FRAC_BITS);
        n2_rl  = 68'(r1_pl[0]) + (68'(r1_pl[1]) <<< 16) + (68'(r1_pl[2]) <<< 32);
        n2_rh  = 68'(r1_ph[0]) + (68'(r1_ph[1]) <<< 16) + (68'(r1_ph[2]) <<< 32);
    end

    // Stage 3: saturation factor, clamped where every result saturates anyway.
    always_comb begin
        logic signed [54:0] fp;
        logic signed [42:0] fr;
        fp = $signed({1'b0, i_cfg.saturation_gain}) * r2_vib;
        fr = 43'(fp >>> FRAC_BITS);
        if (fr > FAC_MAX) begin
            n3_fac = FAC_W'(FAC_MAX);
        end else if (fr < FAC_MIN) begin
            n3_fac = FAC_W'(FAC_MIN);
        end else begin
            n3_fac = FAC_W'(fr);
        end
        n3_tot = 88'(r2_rl) + (88'(r2_rh) <<< HALF_W);
    end

    // Stage 4: channel offsets times the factor in two halves; vignette factor.
    always_comb begin
        t_chan x;
        t_chan l;
        logic signed [24:0] d;
        logic signed [63:0] term;
        l = r3_g.luma;
        for (int i = 0; i < 3; i++) begin
            x = r3_g.chan[i];
            d = 25'(x) - 25'(l);
            n4_ph[i] = d * $signed(r3_fac[FAC_W-1:19]);
            n4_pl[i] = d * $signed({1'b0, r3_fac[18:0]});
        end
        term    = 64'(r3_tot >>> (40 - FRAC_BITS));
        n4_vfac = sat_chan(ONE_L - term);
    end

    // Stage 5: recombine the halves and add luma back.
    always_comb begin
        logic signed [63:0] prod;
        n5_mix      = '0;
        n5_mix.vfac = r4_vfac;
        for (int i = 0; i < 3; i++) begin
            prod = (64'(r4_ph[i]) <<< 19) + 64'(r4_pl[i]);
            n5_mix.chan[i] = sat_chan(64'($signed(r4_g.luma)) + (prod >>> FRAC_BITS));
        end
    end

    // Valid bits travel with the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[STAGES-2:0], i_valid};
        end
    end

    // Data registers.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_g    <= i_grade;
            r1_vp   <= n1_vp;
            r1_pl   <= n1_pl;
            r1_ph   <= n1_ph;
            r2_g    <= r1_g;
            r2_vib  <= n2_vib;
            r2_rl   <= n2_rl;
            r2_rh   <= n2_rh;
            r3_g    <= r2_g;
            r3_fac  <= n3_fac;
            r3_tot  <= n3_tot;
            r4_g    <= r3_g;
            r4_ph   <= n4_ph;
            r4_pl   <= n4_pl;
            r4_vfac <= n4_vfac;
            r5_mix  <= n5_mix;
        end
    end

    assign o_valid = r_v[STAGES-1];
    assign o_mix   = r5_mix;

endmodule

[rtl/core/rgb_color_grading_pixel_unit.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rgb_color_grading_pixel_unit: streaming color grading of RGB pixels
// Input stream: one pixel request per beat with its column and row. Output
// stream: the graded pixel. Configuration: a separate write channel that
// is always ready; registers are meant to change only while no pixel is in
// flight.
//
// A pixel passes 27 register stages: 8 tonal stages, 12 divider stages for
// the chroma ratio (three quotient bits each), 5 saturation and vignette
// stages, the vignette multiply and the output register. Throughput is one
// pixel per clock while the receiver does not stall.
//
// The whole pipeline advances together while the output register is empty
// or being taken. When the receiver stalls with a result waiting, every
// stage holds and the input ready drops; nothing is dropped or repeated.
// Reset clears all valid bits and loads the register defaults: unity
// exposure, contrast and saturation gain, everything else zero.
// ---------------------------------------------------------------------------
module rgb_color_grading_pixel_unit import rcgp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input pixel stream.
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // tdata: in_red[7:0], in_green[15:8], in_blue[23:16], column[35:24],
    // row[47:36]
    input  logic [47:0] i_s_axis_tdata,
    // Output pixel stream.
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // tdata: out_red[7:0], out_green[15:8], out_blue[23:16]
    output logic [23:0] o_m_axis_tdata,
    // Configuration write channel.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);

    t_cfg  r_cfg;
    logic  w_en;

    logic             w_tone_v;
    t_grade           w_tone_g;
    logic [NUM_W-1:0] w_num;
    logic [DEN_W-1:0] w_den;
    logic             w_nz;
    logic             w_div_v;
    t_grade           w_div_g;
    logic [NUM_W-1:0] w_ratio;
    logic             w_sat_v;
    t_mix             w_mix;

    logic             r_f1_v;
    t_chan [2:0]      r_f1_chan, n_f1_chan;
    logic             r_out_v;
    logic [23:0]      r_out, n_out;

    // Whole pipeline moves when the output register can take a new pixel.
    assign w_en            = !r_out_v || i_m_axis_tready;
    assign o_s_axis_tready = w_en;
    assign o_cfg_ready     = 1'b1;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.white_balance   <= '0;
            r_cfg.exposure_gain   <= 18'(ONE_L);
            r_cfg.contrast_gain   <= 14'(ONE_L);
            r_cfg.saturation_gain <= 14'(ONE_L);
            r_cfg.vibrance_amount <= '0;
            r_cfg.tone_amounts    <= '0;
            r_cfg.vignette_scale  <= '0;
            r_cfg.image_size      <= '0;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_reg'(i_cfg_index))
                REG_WHITE_BALANCE:   r_cfg.white_balance   <= i_cfg_data[31:0];
                REG_EXPOSURE_GAIN:   r_cfg.exposure_gain   <= i_cfg_data[17:0];
                REG_CONTRAST_GAIN:   r_cfg.contrast_gain   <= i_cfg_data[13:0];
                REG_SATURATION_GAIN: r_cfg.saturation_gain <= i_cfg_data[13:0];
                REG_VIBRANCE_AMOUNT: r_cfg.vibrance_amount <= $signed(i_cfg_data[13:0]);
                REG_TONE_AMOUNTS:    r_cfg.tone_amounts    <= i_cfg_data;
                REG_VIGNETTE_SCALE:  r_cfg.vignette_scale  <= $signed(i_cfg_data[47:0]);
                REG_IMAGE_SIZE:      r_cfg.image_size      <= i_cfg_data[31:0];
                default: ;
            endcase
        end
    end

    rcgp_tone u_tone (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_cfg   (r_cfg),
        .i_valid (i_s_axis_tvalid),
        .i_pix   (t_pix'(i_s_axis_tdata)),
        .o_valid (w_tone_v),
        .o_grade (w_tone_g),
        .o_num   (w_num),
        .o_den   (w_den),
        .o_nz    (w_nz)
    );

    rcgp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_tone_v),
        .i_grade (w_tone_g),
        .i_num   (w_num),
        .i_den   (w_den),
        .i_nz    (w_nz),
        .o_valid (w_div_v),
        .o_grade (w_div_g),
        .o_ratio (w_ratio)
    );

    rcgp_sat u_sat (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_cfg   (r_cfg),
        .i_valid (w_div_v),
        .i_grade (w_div_g),
        .i_ratio (w_ratio),
        .o_valid (w_sat_v),
        .o_mix   (w_mix)
    );

    // Vignette multiply.
    always_comb begin
        t_chan x;
        t_chan f;
        logic signed [47:0] p;
        f = w_mix.vfac;
        for (int i = 0; i < 3; i++) begin
            x = w_mix.chan[i];
            p = x * f;
            n_f1_chan[i] = sat_chan(64'(p >>> FRAC_BITS));
        end
    end

    // Back to 8-bit codes, clamped to the code range.
    always_comb begin
        t_chan x;
        logic signed [32:0] q;
        logic signed [20:0] v;
        n_out = '0;
        for (int i = 0; i < 3; i++) begin
            x = r_f1_chan[i];
            q = x * 10'sd255;
            v = 21'(q >>> FRAC_BITS);
            if (v < 21'sd0) begin
                n_out[i*8 +: 8] = 8'd0;
            end else if (v > 21'sd255) begin
                n_out[i*8 +: 8] = 8'd255;
            end else begin
                n_out[i*8 +: 8] = v[7:0];
            end
        end
    end

    // Valid bits of the last two stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else if (w_en) begin
            r_f1_v  <= w_sat_v;
            r_out_v <= r_f1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_f1_chan <= n_f1_chan;
            r_out     <= n_out;
        end
    end

    assign o_m_axis_tvalid = r_out_v;
    assign o_m_axis_tdata  = r_out;

    // A stalled pipeline keeps the pixel in the vignette stage.
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_f1_v && !w_en |=> r_f1_v && $stable(r_f1_chan))
        else $error("vignette stage changed while stalled");

endmodule
